// ===== rtl/lnedit_pkg.sv =====
package lnedit_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;
   localparam int CSR_IDX_W = 3;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Result kinds.
   localparam kind_type KIND_CHAR = 2'd0;
   localparam kind_type KIND_EMPTY = 2'd1;
   localparam kind_type KIND_ABORT = 2'd2;

   // Register indexes of the configuration port.
   localparam csr_idx_type CSR_SUB_FROM = 3'd0;
   localparam csr_idx_type CSR_SUB_TO = 3'd1;
   localparam csr_idx_type CSR_ERASE = 3'd2;
   localparam csr_idx_type CSR_KILL = 3'd3;
   localparam csr_idx_type CSR_STOP = 3'd4;
   localparam csr_idx_type CSR_END = 3'd5;
   localparam csr_idx_type CSR_ABORT = 3'd6;

   // Register values after reset.
   localparam char_type RST_SUB_FROM = 8'd97;
   localparam char_type RST_SUB_TO = 8'd122;
   localparam char_type RST_ERASE = 8'd88;
   localparam char_type RST_KILL = 8'd75;
   localparam char_type RST_STOP = 8'd84;
   localparam char_type RST_END = 8'd69;
   localparam char_type RST_ABORT = 8'd11;

endpackage

// ===== rtl/lnedit_line_mem.sv =====
// Line store: one write port and one registered read port.
module lnedit_line_mem #(
   parameter int DEPTH = 32,
   parameter int AW = 5
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  lnedit_pkg::char_type     wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output lnedit_pkg::char_type     rd_data
);

   lnedit_pkg::char_type mem [DEPTH];
   lnedit_pkg::char_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/line_editor_with_erase_kill.sv =====
// Line editor with substitute, erase, kill, stop, end and abort keys.
//
// The req channel carries one typed character per beat. Editing keys and
// plain characters are absorbed and produce no result, so such beats can
// be taken every cycle while idle. The end key plays the stored line out
// on the rsp channel, one character per beat, with rsp_last on the final
// one; an empty line gives one beat of kind "empty line". The abort key
// gives one beat of kind "aborted" and halts the block. After a stop key the
// line is still emitted by the end key, and the block then halts; a halted
// block accepts and discards every further beat.
// The end key is accepted in the idle state; each stored character then
// passes through a line-store read state and an output state, paced by
// the line-store read port and the shared pointer adder, so the block
// takes no new beat until the line is out. Abort and empty-line results
// go straight to the output state. req_stall stays high from the end or
// abort key until the final rsp beat is taken; a stalled rsp beat simply
// holds its payload. Synchronous reset clears the line, the stop and halt
// flags and returns the key registers to their defaults; the line store
// itself is not cleared, since only written entries are ever read back.
// Key registers are written through the csr port, which is always ready.
module line_editor_with_erase_kill #(
   parameter int LINE_LEN = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input characters.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lnedit_pkg::char_type        req_in_char,
   // Results.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lnedit_pkg::char_type        rsp_out_char,
   output lnedit_pkg::kind_type        rsp_kind,
   output logic                        rsp_last,
   output logic                        rsp_stop_after,
   // Configuration writes.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  lnedit_pkg::csr_idx_type     csr_index,
   input  lnedit_pkg::char_type        csr_data
);

   // Length counts 0..LINE_LEN; addresses index 0..LINE_LEN-1.
   localparam int LW = $clog2(LINE_LEN + 1);
   localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_SHOW = 2'd2;

   logic [1:0] state_ff, state_in;

   // Key registers.
   lnedit_pkg::char_type sub_from_ff, sub_to_ff, erase_ff, kill_ff;
   lnedit_pkg::char_type stop_ff, end_ff, abort_ff;

   // Line state.
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          stop_seen_ff, stop_seen_in;
   logic          halted_ff, halted_in;
   logic          halt_pend_ff, halt_pend_in;

   // Result registers (the character itself comes from the store read port).
   lnedit_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_stop_ff, rsp_stop_in;

   // Shared pointer unit: one adder stepping either the length or the
   // emission pointer by plus or minus one.
   logic [LW-1:0] add_opa;
   logic          add_dec;
   logic [LW-1:0] add_sum;

   // Store port controls.
   logic                 wr_en;
   lnedit_pkg::char_type wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   lnedit_pkg::char_type rd_data;

   logic req_take;
   logic rsp_take;
   logic line_full;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign line_full = (len_ff >= LW'(LINE_LEN));

   assign add_sum = add_opa + (add_dec ? {LW{1'b1}} : LW'(1));

   lnedit_line_mem #(
      .DEPTH(LINE_LEN),
      .AW(AW)
   ) u_line_mem (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(len_ff[AW-1:0]),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Configuration registers. The port never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_from_ff <= lnedit_pkg::RST_SUB_FROM;
         sub_to_ff   <= lnedit_pkg::RST_SUB_TO;
         erase_ff    <= lnedit_pkg::RST_ERASE;
         kill_ff     <= lnedit_pkg::RST_KILL;
         stop_ff     <= lnedit_pkg::RST_STOP;
         end_ff      <= lnedit_pkg::RST_END;
         abort_ff    <= lnedit_pkg::RST_ABORT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lnedit_pkg::CSR_SUB_FROM: sub_from_ff <= csr_data;
            lnedit_pkg::CSR_SUB_TO:   sub_to_ff <= csr_data;
            lnedit_pkg::CSR_ERASE:    erase_ff <= csr_data;
            lnedit_pkg::CSR_KILL:     kill_ff <= csr_data;
            lnedit_pkg::CSR_STOP:     stop_ff <= csr_data;
            lnedit_pkg::CSR_END:      end_ff <= csr_data;
            lnedit_pkg::CSR_ABORT:    abort_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      stop_seen_in = stop_seen_ff;
      halted_in    = halted_ff;
      halt_pend_in = halt_pend_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_stop_in  = rsp_stop_ff;
      add_opa      = len_ff;
      add_dec      = 1'b0;
      wr_en        = 1'b0;
      wr_data      = req_in_char;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take && !halted_ff && (req_in_char != '0)) begin
               // Keys are matched in priority order when codes coincide.
               priority if (req_in_char == abort_ff) begin
                  rsp_kind_in  = lnedit_pkg::KIND_ABORT;
                  rsp_last_in  = 1'b1;
                  rsp_stop_in  = 1'b0;
                  halt_pend_in = 1'b1;
                  state_in     = S_SHOW;
               end else if (req_in_char == end_ff) begin
                  rsp_stop_in  = stop_seen_ff;
                  halt_pend_in = stop_seen_ff;
                  if (len_ff == '0) begin
                     rsp_kind_in = lnedit_pkg::KIND_EMPTY;
                     rsp_last_in = 1'b1;
                     state_in    = S_SHOW;
                  end else begin
                     rsp_kind_in = lnedit_pkg::KIND_CHAR;
                     ptr_in      = '0;
                     state_in    = S_READ;
                  end
               end else if (stop_seen_ff) begin
                  // Everything else is dropped once the stop key was seen.
               end else if (req_in_char == sub_from_ff) begin
                  if (!line_full) begin
                     wr_en   = 1'b1;
                     wr_data = sub_to_ff;
                     len_in  = add_sum;
                  end
               end else if (req_in_char == erase_ff) begin
                  add_dec = 1'b1;
                  if (len_ff != '0) begin
                     len_in = add_sum;
                  end
               end else if (req_in_char == kill_ff) begin
                  len_in = '0;
               end else if (req_in_char == stop_ff) begin
                  stop_seen_in = 1'b1;
               end else begin
                  if (!line_full) begin
                     wr_en  = 1'b1;
                     len_in = add_sum;
                  end
               end
            end
         end
         S_READ: begin
            // Fetch the character at the pointer; it is last when the
            // pointer plus one reaches the line length.
            add_opa     = LW'(ptr_ff);
            rd_en       = 1'b1;
            rsp_last_in = (add_sum == len_ff);
            state_in    = S_SHOW;
         end
         S_SHOW: begin
            add_opa = LW'(ptr_ff);
            if (rsp_take) begin
               if (rsp_last_ff) begin
                  len_in       = '0;
                  stop_seen_in = 1'b0;
                  halted_in    = halt_pend_ff;
                  halt_pend_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  ptr_in   = add_sum[AW-1:0];
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         stop_seen_ff <= 1'b0;
         halted_ff    <= 1'b0;
         halt_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         stop_seen_ff <= stop_seen_in;
         halted_ff    <= halted_in;
         halt_pend_ff <= halt_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
      rsp_stop_ff <= rsp_stop_in;
   end

   // Input is taken only while no line is being played out.
   assign req_stall = (state_ff != S_IDLE);

   assign rsp_valid      = (state_ff == S_SHOW);
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_stop_after = rsp_last_ff && rsp_stop_ff;
   assign rsp_out_char   = (rsp_kind_ff == lnedit_pkg::KIND_CHAR) ? rd_data : '0;

endmodule

// ===== rtl/lnedit_checker.sv =====
// Port-level checks for the line editor.
module lnedit_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input lnedit_pkg::char_type    rsp_out_char,
   input lnedit_pkg::kind_type    rsp_kind,
   input logic                    rsp_last,
   input logic                    rsp_stop_after
);

   // A result beat held by the receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) &&
      $stable(rsp_kind) && $stable(rsp_last) && $stable(rsp_stop_after))
      else $error("rsp beat changed while stalled");

   // Input is held off while any result is being presented.
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during line output");

   // Empty-line and abort results are single beats with no character.
   a_non_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != lnedit_pkg::KIND_CHAR) |->
      rsp_last && (rsp_out_char == '0))
      else $error("non-character result malformed");

   // The stop flag only marks the final beat, and never an abort.
   a_stop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_after |->
      rsp_last && (rsp_kind != lnedit_pkg::KIND_ABORT))
      else $error("stop_after on wrong beat");

endmodule

bind line_editor_with_erase_kill lnedit_checker u_lnedit_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_out_char(rsp_out_char),
   .rsp_kind(rsp_kind),
   .rsp_last(rsp_last),
   .rsp_stop_after(rsp_stop_after)
);
